[rtl/drc_pkg.sv]
package drc_pkg;

   // Packet layout
   localparam int unsigned MAX_PACKET  = 1500;
   localparam int unsigned OFFSET_W    = 11;
   localparam logic [OFFSET_W-1:0] HDR_LEN       = 11'd240;
   localparam logic [OFFSET_W-1:0] MAGIC_FIRST   = 11'd236;
   localparam logic [OFFSET_W-1:0] MAGIC_LAST    = 11'd239;
   localparam logic [OFFSET_W-1:0] XID_FIRST     = 11'd4;
   localparam logic [OFFSET_W-1:0] XID_LAST      = 11'd7;
   localparam logic [OFFSET_W-1:0] MAX_OFFSET    = OFFSET_W'(MAX_PACKET);
   localparam logic [31:0]         MAGIC_WORD    = 32'h6382_5363;
   localparam logic [7:0]          OP_REQUEST    = 8'd1;

   // Option codes and lengths
   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_END      = 8'd255;
   localparam logic [7:0] OPT_TYPE     = 8'd53;
   localparam logic [7:0] OPT_REQ      = 8'd50;
   localparam logic [7:0] OPT_TYPE_LEN = 8'd1;
   localparam logic [7:0] OPT_REQ_LEN  = 8'd4;

   // Message types
   localparam logic [7:0] MSG_DISCOVER = 8'd1;
   localparam logic [7:0] MSG_REQUEST  = 8'd3;

   // Verdict codes
   localparam logic [1:0] VERDICT_IGNORE = 2'd0;
   localparam logic [1:0] VERDICT_OFFER  = 2'd1;
   localparam logic [1:0] VERDICT_ACK    = 2'd2;
   localparam logic [1:0] VERDICT_NAK    = 2'd3;

   // Queue between parser and verdict stage
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_CODE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_VAL  = 4'b0100,
      PH_DONE = 4'b1000
   } drc_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } drc_req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [7:0]  message_type;
      logic [31:0] requested_addr;
      logic [31:0] transaction_id;
   } drc_rsp_type;

   // Per-packet summary handed from parser to verdict stage
   typedef struct packed {
      logic        header_ok;
      logic [7:0]  message_type;
      logic [31:0] requested_addr;
      logic [31:0] transaction_id;
   } drc_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } drc_qstat_type;

endpackage

[rtl/drc_front.sv]
module drc_front
   import drc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  drc_req_type req_payload,
   input  logic        queue_full,
   output logic        push,
   output drc_rec_type push_rec
);

   logic [OFFSET_W-1:0] byte_offset_ff, byte_offset_in;
   drc_phase_type       phase_ff, phase_in;
   logic [7:0]          code_ff, code_in;
   logic [7:0]          left_ff, left_in;
   logic [31:0]         shift_ff, shift_in;
   logic [7:0]          type_ff, type_in;
   logic [31:0]         req_addr_ff, req_addr_in;
   logic [31:0]         xid_ff, xid_in;
   logic                hdr_good_ff, hdr_good_in;
   logic                accept;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   // Per-byte parse update
   always_comb begin
      logic [7:0]          b;
      logic [OFFSET_W-1:0] pos;
      b   = req_payload.data_byte;
      pos = byte_offset_ff;

      byte_offset_in = byte_offset_ff;
      phase_in       = phase_ff;
      code_in        = code_ff;
      left_in        = left_ff;
      shift_in       = shift_ff;
      type_in        = type_ff;
      req_addr_in    = req_addr_ff;
      xid_in         = xid_ff;
      hdr_good_in    = hdr_good_ff;

      if (accept && (pos < MAX_OFFSET)) begin
         if (pos == '0) begin
            if (b != OP_REQUEST) begin
               hdr_good_in = 1'b0;
            end
         end else if ((pos >= XID_FIRST) && (pos <= XID_LAST)) begin
            xid_in = {xid_ff[23:0], b};
         end else if ((pos >= MAGIC_FIRST) && (pos <= MAGIC_LAST)) begin
            shift_in = {shift_ff[23:0], b};
            if (pos == MAGIC_LAST) begin
               if (shift_in != MAGIC_WORD) begin
                  hdr_good_in = 1'b0;
               end
               shift_in = '0;
            end
         end else if (pos >= HDR_LEN) begin
            // Option walk: code, length, value
            case (phase_ff)
               PH_CODE: begin
                  if (b == OPT_END) begin
                     phase_in = PH_DONE;
                  end else if (b != OPT_PAD) begin
                     code_in  = b;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  // wrong length: drop the code so nothing is captured
                  if (((code_ff == OPT_TYPE) && (b != OPT_TYPE_LEN)) ||
                      ((code_ff == OPT_REQ) && (b != OPT_REQ_LEN))) begin
                     code_in = OPT_PAD;
                  end
                  left_in  = b;
                  shift_in = '0;
                  phase_in = (b == 8'd0) ? PH_CODE : PH_VAL;
               end
               PH_VAL: begin
                  shift_in = {shift_ff[23:0], b};
                  left_in  = left_ff - 8'd1;
                  if (left_in == 8'd0) begin
                     if (code_ff == OPT_TYPE) begin
                        type_in = shift_in[7:0];
                     end else if (code_ff == OPT_REQ) begin
                        req_addr_in = shift_in;
                     end
                     phase_in = PH_CODE;
                  end
               end
               default: begin
               end
            endcase
         end
         byte_offset_in = pos + 11'd1;
      end
   end

   // Summary of the finished packet
   assign push                    = accept & req_payload.last_byte;
   assign push_rec.header_ok      = (byte_offset_in >= HDR_LEN) & hdr_good_in;
   assign push_rec.message_type   = type_in;
   assign push_rec.requested_addr = req_addr_in;
   assign push_rec.transaction_id = xid_in;

   // Parse state; cleared after each packet
   always_ff @(posedge clock) begin
      if (reset || push) begin
         byte_offset_ff <= '0;
         phase_ff       <= PH_CODE;
         code_ff        <= '0;
         left_ff        <= '0;
         shift_ff       <= '0;
         type_ff        <= '0;
         req_addr_ff    <= '0;
         xid_ff         <= '0;
         hdr_good_ff    <= 1'b1;
      end else begin
         byte_offset_ff <= byte_offset_in;
         phase_ff       <= phase_in;
         code_ff        <= code_in;
         left_ff        <= left_in;
         shift_ff       <= shift_in;
         type_ff        <= type_in;
         req_addr_ff    <= req_addr_in;
         xid_ff         <= xid_in;
         hdr_good_ff    <= hdr_good_in;
      end
   end

endmodule

[rtl/drc_queue.sv]
module drc_queue
   import drc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  drc_rec_type   push_rec,
   input  logic          pop,
   output drc_rec_type   head_rec,
   output drc_qstat_type status
);

   drc_rec_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_rec     = entries_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

[rtl/drc_back.sv]
module drc_back
   import drc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  drc_rec_type head_rec,
   input  logic        queue_empty,
   output logic        pop,
   input  logic [31:0] offered_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output drc_rsp_type rsp_payload
);

   logic        rsp_valid_ff, rsp_valid_in;
   drc_rsp_type rsp_ff, rsp_in;
   logic        load;

   // Output register takes a new transaction when empty or being drained
   assign load         = ~rsp_valid_ff | ~rsp_stall;
   assign pop          = load & ~queue_empty;
   assign rsp_valid_in = load ? ~queue_empty : rsp_valid_ff;

   // Verdict from the packet summary
   always_comb begin
      logic [1:0] v;
      v = VERDICT_IGNORE;
      if (head_rec.header_ok) begin
         if (head_rec.message_type == MSG_DISCOVER) begin
            v = VERDICT_OFFER;
         end else if (head_rec.message_type == MSG_REQUEST) begin
            v = VERDICT_ACK;
         end
      end
      if ((v != VERDICT_IGNORE) && (head_rec.requested_addr != '0) &&
          (head_rec.requested_addr != offered_addr)) begin
         v = VERDICT_NAK;
      end
      rsp_in.verdict        = v;
      rsp_in.message_type   = head_rec.message_type;
      rsp_in.requested_addr = head_rec.requested_addr;
      rsp_in.transaction_id = head_rec.transaction_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/dhcp_request_classifier.sv]
// rsp_valid rises once the packet summary pushed with the last byte has passed
// through the queue and the output register.
// Throughput: one byte per cycle; the parser stalls only while the two-entry queue is full.
// Verdict stage retires one transaction per cycle via its output register unless stalled.
// Reset (synchronous, active high) clears the parse state, the queue, the output
// valid bit and offered_addr (to zero); there is no clearing pass.
module dhcp_request_classifier
   import drc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  drc_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output drc_rsp_type rsp_payload,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]   offered_addr_ff;
   logic          push, pop;
   drc_rec_type   push_rec, head_rec;
   drc_qstat_type qstat;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         offered_addr_ff <= '0;
      end else if (csr_wr_en) begin
         offered_addr_ff <= csr_wr_data;
      end
   end

   drc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (qstat.full),
      .push        (push),
      .push_rec    (push_rec)
   );

   drc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (qstat)
   );

   drc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_rec     (head_rec),
      .queue_empty  (qstat.empty),
      .pop          (pop),
      .offered_addr (offered_addr_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // Offer or ack only for a discover or request message type
   a_verdict_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.verdict != VERDICT_IGNORE)) |->
      ((rsp_payload.message_type == MSG_DISCOVER) ||
       (rsp_payload.message_type == MSG_REQUEST)))
      else $error("verdict given for a non-classified message type");

   // A nak always carries a nonzero requested address
   a_nak_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.verdict == VERDICT_NAK)) |->
      (rsp_payload.requested_addr != '0))
      else $error("nak without a requested address");

   // Queue cannot be full and empty at once
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue reports full and empty");

   // Nothing is presented right after reset
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
